### src/pslt_pkg.sv
`timescale 1ns / 1ps
// shared types, sizes and helpers for the pipeline stage latency tracker
// no dependencies
package pslt_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int SADDR_W     = IDX_W + 2;

  localparam logic [1:0] CFG_MAX_AGE      = 2'd0;
  localparam logic [1:0] CFG_MAX_INFLIGHT = 2'd1;

  localparam logic [1:0] STG_CAPTURE  = 2'd0;
  localparam logic [1:0] STG_ESTIMATE = 2'd1;
  localparam logic [1:0] STG_CONTROL  = 2'd2;
  localparam logic [1:0] STG_ACTUATE  = 2'd3;

  typedef struct packed {
    logic [31:0] frame;
    logic [31:0] seq;
    logic [3:0]  present;
  } entry_t;

  // exact difference of two 48-bit times, clamped to signed 32 bits
  function automatic logic signed [31:0] sat_diff(input logic [47:0] t_from,
                                                  input logic [47:0] t_to);
    logic signed [48:0] d;
    d = $signed({1'b0, t_to}) - $signed({1'b0, t_from});
    if (d > 49'sd2147483647) begin
      sat_diff = 32'sh7fffffff;
    end else if (d < -49'sd2147483648) begin
      sat_diff = 32'sh80000000;
    end else begin
      sat_diff = d[31:0];
    end
  endfunction

endpackage

### src/pslt_in_if.sv
`timescale 1ns / 1ps
// request channel carrying one stage stamp
// no dependencies
interface pslt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [31:0] stamp_fid;
  logic [47:0] timestamp_us;

  modport source (output valid, req_type, stamp_fid, timestamp_us, input ready);
  modport sink (input valid, req_type, stamp_fid, timestamp_us, output ready);
endinterface

### src/pslt_out_if.sv
`timescale 1ns / 1ps
// result channel carrying one completed frame and running statistics
// no dependencies
interface pslt_out_if;
  logic               valid;
  logic               ready;
  logic        [31:0] done_fid;
  logic signed [31:0] vision_us;
  logic signed [31:0] ctl_us;
  logic signed [31:0] act_us;
  logic signed [31:0] total_us;
  logic        [31:0] sample_count;
  logic signed [31:0] total_min_us;
  logic signed [31:0] total_max_us;
  logic signed [47:0] total_sum_us;
  logic signed [31:0] vision_max_us;
  logic signed [31:0] control_max_us;
  logic signed [31:0] actuate_max_us;

  modport source (output valid, done_fid, vision_us, ctl_us, act_us, total_us,
                  sample_count, total_min_us, total_max_us, total_sum_us, vision_max_us,
                  control_max_us, actuate_max_us, input ready);
  modport sink (input valid, done_fid, vision_us, ctl_us, act_us, total_us,
                sample_count, total_min_us, total_max_us, total_sum_us, vision_max_us,
                control_max_us, actuate_max_us, output ready);
endinterface

### src/pipeline_stage_latency_tracker_core.sv
`timescale 1ns / 1ps
// pipeline stage latency tracker top level
// depends on pslt_pkg, pslt_in_if, pslt_out_if
//
// in_chan takes one stage stamp per request (stage, frame id, microsecond time).
// out_chan gives one result when a frame holds all four stamps: the stage
// durations, the total and the running statistics.
// cfg_we/cfg_idx/cfg_wdata write max_age_us (index 0) and max_inflight (index 1);
// the user must write them only while the block is idle; the block does not enforce it.
// the in-flight table lives in an entry memory and a stamp memory, both with a
// registered read. every table pass reads the entry memory one slot a cycle.
// a request costs one lookup pass, one age pass when max_age_us is set (with an
// S_AGE check when the oldest entry has a capture stamp), one pass per pruned
// entry (through S_AGE for an age drop) and a final count pass; a completed
// frame then goes through S_RD, S_DIFF and S_STAT.
// one request is worked on at a time; in_chan.ready is high only when idle.
// the result sits in an output register, so a new request is taken while
// out_chan is stalled; a second result waits until the first is taken.
// reset (rst_n low, synchronous) empties the table and clears the statistics.
module pipeline_stage_latency_tracker_core (
  input  logic             clk,
  input  logic             rst_n,
  pslt_in_if.sink          in_chan,
  pslt_out_if.source       out_chan,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_idx,
  input  logic [31:0]      cfg_wdata
);
  import pslt_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_SCAN = 7'b0000010,
    S_DEC  = 7'b0000100,
    S_AGE  = 7'b0001000,
    S_RD   = 7'b0010000,
    S_DIFF = 7'b0100000,
    S_STAT = 7'b1000000
  } state_t;

  typedef enum logic [2:0] {
    PH_LOOK = 3'b001,
    PH_AGE  = 3'b010,
    PH_CNT  = 3'b100
  } phase_t;

  state_t state_r;
  phase_t phase_r;

  logic [31:0] max_age_r;
  logic [4:0]  max_inflight_r;

  // request
  logic [1:0]  stage_r;
  logic [31:0] fid_r;
  logic [47:0] now_r;

  logic [TABLE_DEPTH-1:0] valid_r;
  logic [31:0] next_seq_r;

  entry_t entry_mem [TABLE_DEPTH];
  entry_t emem_rd_r;
  logic   emem_we;
  logic [IDX_W-1:0] emem_wa;
  entry_t emem_wd;

  logic [47:0] stamp_mem [TABLE_DEPTH*4];
  logic [47:0] smem_rd_r;
  logic        smem_we;
  logic [SADDR_W-1:0] smem_wa, smem_ra;

  // scan
  logic [CNT_W-1:0] scan_cnt_r;
  logic             p_act_r, p_vld_r;
  logic [IDX_W-1:0] p_idx_r;
  logic [CNT_W-1:0] vcount_r;
  logic             match_r, free_found_r, old_found_r;
  logic [IDX_W-1:0] match_idx_r, free_idx_r, old_idx_r;
  logic [31:0]      match_seq_r, best_age_r;
  logic [3:0]       match_pres_r, old_pres_r;

  logic [IDX_W-1:0] slot_r;
  logic [3:0]       slot_pres_r;
  logic [2:0]       rd_cnt_r;
  logic [47:0]      t_r [4];
  logic signed [31:0] vis_r, ctl_r, act_r, tot_r;

  // statistics
  logic               started_r;
  logic [31:0]        done_count_r;
  logic signed [31:0] tmin_r, tmax_r, vmax_r, cmax_r, amax_r;
  logic signed [47:0] tsum_r;

  logic               out_valid_r;
  logic [31:0]        o_fid_r, o_cnt_r;
  logic signed [31:0] o_vis_r, o_ctl_r, o_act_r, o_tot_r;
  logic signed [31:0] o_tmin_r, o_tmax_r, o_vmax_r, o_cmax_r, o_amax_r;
  logic signed [47:0] o_tsum_r;

  logic [31:0]        cur_age;
  logic signed [48:0] age_diff;
  logic signed [48:0] sum_wide;
  logic signed [47:0] sum_nxt;
  logic signed [31:0] tmin_nxt, tmax_nxt, vmax_nxt, cmax_nxt, amax_nxt;
  logic [31:0]        done_count_nxt;
  logic [3:0]         stage_bit;
  logic               over_count;

  assign stage_bit  = 4'b0001 << stage_r;
  assign cur_age    = next_seq_r - emem_rd_r.seq;
  assign age_diff   = $signed({1'b0, now_r}) - $signed({1'b0, smem_rd_r});
  assign over_count = (max_inflight_r != 5'd0) &&
                      ({{(32-CNT_W){1'b0}}, vcount_r} > {27'd0, max_inflight_r});

  // entry memory
  always_ff @(posedge clk) begin
    if (emem_we) begin
      entry_mem[emem_wa] <= emem_wd;
    end
    emem_rd_r <= entry_mem[scan_cnt_r[IDX_W-1:0]];
  end

  // stamp memory
  always_ff @(posedge clk) begin
    if (smem_we) begin
      stamp_mem[smem_wa] <= now_r;
    end
    smem_rd_r <= stamp_mem[smem_ra];
  end

  always_comb begin
    emem_we = 1'b0;
    emem_wa = match_r ? match_idx_r :
              (vcount_r == CNT_W'(TABLE_DEPTH)) ? old_idx_r : free_idx_r;
    emem_wd.frame   = fid_r;
    emem_wd.seq     = match_r ? match_seq_r : next_seq_r;
    emem_wd.present = match_r ? (match_pres_r | stage_bit) : stage_bit;
    smem_we = 1'b0;
    smem_wa = {emem_wa, stage_r};
    smem_ra = {slot_r, rd_cnt_r[1:0]};
    if (state_r == S_DEC && phase_r == PH_LOOK) begin
      emem_we = 1'b1;
      smem_we = 1'b1;
    end
    if (state_r == S_DEC) begin
      smem_ra = {old_idx_r, STG_CAPTURE};
    end
  end

  // statistics update
  always_comb begin
    if (!started_r) begin
      tmin_nxt = tot_r;
      tmax_nxt = tot_r;
      vmax_nxt = vis_r;
      cmax_nxt = ctl_r;
      amax_nxt = act_r;
    end else begin
      tmin_nxt = (tot_r < tmin_r) ? tot_r : tmin_r;
      tmax_nxt = (tot_r > tmax_r) ? tot_r : tmax_r;
      vmax_nxt = (vis_r > vmax_r) ? vis_r : vmax_r;
      cmax_nxt = (ctl_r > cmax_r) ? ctl_r : cmax_r;
      amax_nxt = (act_r > amax_r) ? act_r : amax_r;
    end
    done_count_nxt = (done_count_r == 32'hffffffff) ? done_count_r : done_count_r + 32'd1;
    sum_wide = {tsum_r[47], tsum_r} + {{17{tot_r[31]}}, tot_r};
    if (sum_wide > 49'sd140737488355327) begin
      sum_nxt = 48'sh7fffffffffff;
    end else if (sum_wide < -49'sd140737488355328) begin
      sum_nxt = 48'sh800000000000;
    end else begin
      sum_nxt = sum_wide[47:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      phase_r        <= PH_LOOK;
      max_age_r      <= 32'd0;
      max_inflight_r <= 5'd0;
      valid_r        <= '0;
      next_seq_r     <= 32'd0;
      scan_cnt_r     <= '0;
      p_act_r        <= 1'b0;
      rd_cnt_r       <= 3'd0;
      started_r      <= 1'b0;
      done_count_r   <= 32'd0;
      tmin_r         <= 32'sd0;
      tmax_r         <= 32'sd0;
      tsum_r         <= 48'sd0;
      vmax_r         <= 32'sd0;
      cmax_r         <= 32'sd0;
      amax_r         <= 32'sd0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_MAX_AGE:      max_age_r      <= cfg_wdata;
          CFG_MAX_INFLIGHT: max_inflight_r <= cfg_wdata[4:0];
          default: ;
        endcase
      end
      // in S_STAT the output register is refilled instead
      if (out_valid_r && out_chan.ready && state_r != S_STAT) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_chan.valid) begin
            stage_r    <= in_chan.req_type;
            fid_r      <= in_chan.stamp_fid;
            now_r      <= in_chan.timestamp_us;
            phase_r    <= PH_LOOK;
            scan_cnt_r <= '0;
            state_r    <= S_SCAN;
          end
        end

        S_SCAN: begin
          if (scan_cnt_r == '0) begin
            vcount_r     <= '0;
            match_r      <= 1'b0;
            free_found_r <= 1'b0;
            old_found_r  <= 1'b0;
          end
          if (p_act_r) begin
            if (p_vld_r) begin
              vcount_r <= vcount_r + CNT_W'(1);
              if (!match_r && emem_rd_r.frame == fid_r) begin
                match_r      <= 1'b1;
                match_idx_r  <= p_idx_r;
                match_seq_r  <= emem_rd_r.seq;
                match_pres_r <= emem_rd_r.present;
              end
              if (!old_found_r || cur_age > best_age_r) begin
                old_found_r <= 1'b1;
                old_idx_r   <= p_idx_r;
                best_age_r  <= cur_age;
                old_pres_r  <= emem_rd_r.present;
              end
            end else if (!free_found_r) begin
              free_found_r <= 1'b1;
              free_idx_r   <= p_idx_r;
            end
          end
          if (scan_cnt_r == CNT_W'(TABLE_DEPTH)) begin
            p_act_r <= 1'b0;
            state_r <= S_DEC;
          end else begin
            p_act_r    <= 1'b1;
            p_vld_r    <= valid_r[scan_cnt_r[IDX_W-1:0]];
            p_idx_r    <= scan_cnt_r[IDX_W-1:0];
            scan_cnt_r <= scan_cnt_r + CNT_W'(1);
          end
        end

        S_DEC: begin
          scan_cnt_r <= '0;
          case (phase_r)
            PH_LOOK: begin
              if (match_r) begin
                slot_r      <= match_idx_r;
                slot_pres_r <= match_pres_r | stage_bit;
              end else begin
                // table full: the oldest entry gives up its slot
                if (vcount_r == CNT_W'(TABLE_DEPTH)) begin
                  slot_r <= old_idx_r;
                end else begin
                  slot_r <= free_idx_r;
                end
                slot_pres_r <= stage_bit;
                next_seq_r  <= next_seq_r + 32'd1;
              end
              valid_r[emem_wa] <= 1'b1;
              phase_r <= (max_age_r != 32'd0) ? PH_AGE : PH_CNT;
              state_r <= S_SCAN;
            end
            PH_AGE: begin
              if (old_found_r && old_pres_r[0]) begin
                state_r <= S_AGE;
              end else begin
                phase_r <= PH_CNT;
                state_r <= S_SCAN;
              end
            end
            PH_CNT: begin
              if (old_found_r && over_count) begin
                valid_r[old_idx_r] <= 1'b0;
                state_r <= S_SCAN;
              end else if (valid_r[slot_r] && slot_pres_r == 4'hf) begin
                rd_cnt_r <= 3'd0;
                state_r  <= S_RD;
              end else begin
                state_r <= S_IDLE;
              end
            end
            default: state_r <= S_IDLE;
          endcase
        end

        S_AGE: begin
          // capture stamp of the oldest entry is in smem_rd_r
          if (age_diff > $signed({17'd0, max_age_r})) begin
            valid_r[old_idx_r] <= 1'b0;
          end else begin
            phase_r <= PH_CNT;
          end
          scan_cnt_r <= '0;
          state_r    <= S_SCAN;
        end

        S_RD: begin
          if (rd_cnt_r != 3'd0) begin
            t_r[rd_cnt_r[1:0] - 2'd1] <= smem_rd_r;
          end
          if (rd_cnt_r == 3'd4) begin
            state_r <= S_DIFF;
          end else begin
            rd_cnt_r <= rd_cnt_r + 3'd1;
          end
        end

        S_DIFF: begin
          vis_r   <= sat_diff(t_r[0], t_r[1]);
          ctl_r   <= sat_diff(t_r[1], t_r[2]);
          act_r   <= sat_diff(t_r[2], t_r[3]);
          tot_r   <= sat_diff(t_r[0], t_r[3]);
          state_r <= S_STAT;
        end

        S_STAT: begin
          if (!out_valid_r || out_chan.ready) begin
            started_r    <= 1'b1;
            tmin_r       <= tmin_nxt;
            tmax_r       <= tmax_nxt;
            vmax_r       <= vmax_nxt;
            cmax_r       <= cmax_nxt;
            amax_r       <= amax_nxt;
            done_count_r <= done_count_nxt;
            tsum_r       <= sum_nxt;
            valid_r[slot_r] <= 1'b0;
            out_valid_r  <= 1'b1;
            o_fid_r      <= fid_r;
            o_vis_r      <= vis_r;
            o_ctl_r      <= ctl_r;
            o_act_r      <= act_r;
            o_tot_r      <= tot_r;
            o_cnt_r      <= done_count_nxt;
            o_tmin_r     <= tmin_nxt;
            o_tmax_r     <= tmax_nxt;
            o_tsum_r     <= sum_nxt;
            o_vmax_r     <= vmax_nxt;
            o_cmax_r     <= cmax_nxt;
            o_amax_r     <= amax_nxt;
            state_r      <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_chan.ready           = (state_r == S_IDLE);
  assign out_chan.valid          = out_valid_r;
  assign out_chan.done_fid       = o_fid_r;
  assign out_chan.vision_us      = o_vis_r;
  assign out_chan.ctl_us         = o_ctl_r;
  assign out_chan.act_us         = o_act_r;
  assign out_chan.total_us       = o_tot_r;
  assign out_chan.sample_count   = o_cnt_r;
  assign out_chan.total_min_us   = o_tmin_r;
  assign out_chan.total_max_us   = o_tmax_r;
  assign out_chan.total_sum_us   = o_tsum_r;
  assign out_chan.vision_max_us  = o_vmax_r;
  assign out_chan.control_max_us = o_cmax_r;
  assign out_chan.actuate_max_us = o_amax_r;

endmodule
